### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for concurrent assertions on a clock with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/rrdf_pkg.sv
// ----------------------------------------------------------------------------
// Route request duplicate filter package
// Controller states and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rrdf_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PAIR,
      ST_TOUCH,
      ST_WRITE
   } state_type;

   localparam logic CSR_TABLE_LIMIT = 1'b0;
   localparam logic CSR_ID_LIMIT    = 1'b1;

   localparam logic [6:0] TABLE_LIMIT_RESET = 7'd64;
   localparam logic [4:0] ID_LIMIT_RESET    = 5'd16;

endpackage

`default_nettype wire

### hdl/route_request_duplicate_filter.sv
// ----------------------------------------------------------------------------
// Route request duplicate filter
// Remembers recent (target, id) pairs per initiator in a least recently used
// table and flags route requests that were already seen.
//
//   Channel   Ports                                   Handshake
//   request   req_initiator_addr, req_target_addr,    start & !busy
//             req_request_id
//   response  rsp_is_duplicate, rsp_entry_evicted     rsp_valid, one cycle
//   csr       csr_index, csr_wdata                    csr_write_en
//
// Each accepted word makes a pass over the entry memory to look up the
// initiator, a pass over its pair ring, a second pass that ages the recency
// ranks and a write-back. A new initiator, or one with no stored pairs, skips
// the ring pass; a duplicate skips the aging pass and the write-back. Reset
// clears all valid bits at once.
// The response cannot be stalled; busy falls in the cycle it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module route_request_duplicate_filter
   import rrdf_pkg::*;
#(
   parameter int TABLE_DEPTH   = 64,
   parameter int IDS_PER_ENTRY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_initiator_addr,
   input  wire logic [31:0] req_target_addr,
   input  wire logic [15:0] req_request_id,
   output logic             rsp_valid,
   output logic             rsp_is_duplicate,
   output logic             rsp_entry_evicted,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_wdata
);

   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int SW  = (IDS_PER_ENTRY > 1) ? $clog2(IDS_PER_ENTRY) : 1;
   localparam int KW  = $clog2(IDS_PER_ENTRY + 1);
   localparam int PAW = $clog2(TABLE_DEPTH * IDS_PER_ENTRY);
   localparam int EW  = 32 + IW + KW + SW;
   localparam int PD  = TABLE_DEPTH * IDS_PER_ENTRY;

   state_type state_ff, state_in;

   logic [6:0] table_limit_ff;
   logic [4:0] id_limit_ff;
   logic [CW-1:0] tlim;
   logic [KW-1:0] ilim;

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [EW-1:0] entry_mem_ff [TABLE_DEPTH];
   logic [47:0]   pair_mem_ff [PD];
   logic [EW-1:0] ent_rdata_ff;
   logic [47:0]   pair_rdata_ff;

   logic          ent_we;
   logic [IW-1:0] ent_waddr;
   logic [EW-1:0] ent_wdata;
   logic [PAW-1:0] pair_raddr;
   logic [PAW-1:0] pair_waddr;

   logic [31:0] ini_ff;
   logic [31:0] tgt_ff;
   logic [15:0] id_ff;

   logic [CW-1:0] idx_ff;
   logic [IW-1:0] idx_d_ff;
   logic          rv_ff;

   logic          hit_ff;
   logic [IW-1:0] hit_idx_ff;
   logic [IW-1:0] hit_rec_ff;
   logic [KW-1:0] hit_cnt_ff;
   logic [SW-1:0] hit_head_ff;
   logic [CW-1:0] used_ff;
   logic          lru_found_ff;
   logic [IW-1:0] lru_idx_ff;
   logic [IW-1:0] lru_rec_ff;
   logic          free_found_ff;
   logic [IW-1:0] free_idx_ff;

   logic [IW-1:0] e_ff;
   logic [IW-1:0] old_rank_ff;
   logic          all_ff;
   logic [KW-1:0] cnt_ff;
   logic [SW-1:0] head_ff;
   logic          evict_ff;
   logic [KW-1:0] k_ff;
   logic [SW-1:0] slot_ff;
   logic          dup_ff;

   logic rsp_valid_ff;
   logic rsp_dup_ff;
   logic rsp_evict_ff;

   logic [31:0]   r_ini;
   logic [IW-1:0] r_rec;
   logic [KW-1:0] r_cnt;
   logic [SW-1:0] r_head;

   logic issue_entry;
   logic issue_pair;
   logic scan_done;
   logic pair_done;
   logic alloc_evict;

   logic [SW-1:0] new_head;
   logic [KW-1:0] new_cnt;
   logic [SW+KW:0] slot_sum;
   logic [SW-1:0] wr_slot;
   logic [SW:0]   slot_next;

   assign r_ini  = ent_rdata_ff[EW-1 -: 32];
   assign r_rec  = ent_rdata_ff[IW+KW+SW-1 -: IW];
   assign r_cnt  = ent_rdata_ff[KW+SW-1 -: KW];
   assign r_head = ent_rdata_ff[SW-1:0];

   always_comb begin
      if (table_limit_ff == 7'd0) begin
         tlim = CW'(1);
      end else if ((CW+7)'(table_limit_ff) > (CW+7)'(TABLE_DEPTH)) begin
         tlim = CW'(TABLE_DEPTH);
      end else begin
         tlim = CW'(table_limit_ff);
      end
      if (id_limit_ff == 5'd0) begin
         ilim = KW'(1);
      end else if ((KW+5)'(id_limit_ff) > (KW+5)'(IDS_PER_ENTRY)) begin
         ilim = KW'(IDS_PER_ENTRY);
      end else begin
         ilim = KW'(id_limit_ff);
      end
   end

   assign issue_entry = ((state_ff == ST_SCAN) || (state_ff == ST_TOUCH)) &&
                        (idx_ff != CW'(TABLE_DEPTH));
   assign issue_pair  = (state_ff == ST_PAIR) && (k_ff != cnt_ff);
   assign scan_done   = (idx_ff == CW'(TABLE_DEPTH)) && !rv_ff;
   assign pair_done   = (k_ff == cnt_ff) && !rv_ff;
   assign alloc_evict = ((used_ff >= tlim) || !free_found_ff) && lru_found_ff;

   assign slot_next = (SW+1)'(slot_ff) + (SW+1)'(1);

   always_comb begin
      if (cnt_ff >= ilim) begin
         new_cnt = cnt_ff - KW'(1);
         if ((SW+1)'(head_ff) + (SW+1)'(1) == (SW+1)'(IDS_PER_ENTRY)) begin
            new_head = '0;
         end else begin
            new_head = SW'((SW+1)'(head_ff) + (SW+1)'(1));
         end
      end else begin
         new_cnt  = cnt_ff;
         new_head = head_ff;
      end
      slot_sum = (SW+KW+1)'(new_head) + (SW+KW+1)'(new_cnt);
      if (slot_sum >= (SW+KW+1)'(IDS_PER_ENTRY)) begin
         wr_slot = SW'(slot_sum - (SW+KW+1)'(IDS_PER_ENTRY));
      end else begin
         wr_slot = SW'(slot_sum);
      end
   end

   assign pair_raddr = PAW'(e_ff) * PAW'(IDS_PER_ENTRY) + PAW'(slot_ff);
   assign pair_waddr = PAW'(e_ff) * PAW'(IDS_PER_ENTRY) + PAW'(wr_slot);

   always_comb begin
      state_in  = state_ff;
      ent_we    = 1'b0;
      ent_waddr = idx_d_ff;
      ent_wdata = {r_ini, r_rec + IW'(1), r_cnt, r_head};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (hit_ff && (hit_cnt_ff != '0)) begin
                  state_in = ST_PAIR;
               end else begin
                  state_in = ST_TOUCH;
               end
            end
         end
         ST_PAIR: begin
            if (pair_done) begin
               state_in = dup_ff ? ST_IDLE : ST_TOUCH;
            end
         end
         ST_TOUCH: begin
            if (rv_ff && (idx_d_ff != e_ff) && valid_ff[idx_d_ff] &&
                (all_ff || (r_rec < old_rank_ff))) begin
               ent_we = 1'b1;
            end
            if (scan_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ent_we    = 1'b1;
            ent_waddr = e_ff;
            ent_wdata = {ini_ff, IW'(0), new_cnt + KW'(1), new_head};
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem_ff[ent_waddr] <= ent_wdata;
      end
      ent_rdata_ff <= entry_mem_ff[idx_ff[IW-1:0]];
      if (state_ff == ST_WRITE) begin
         pair_mem_ff[pair_waddr] <= {tgt_ff, id_ff};
      end
      pair_rdata_ff <= pair_mem_ff[pair_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_limit_ff <= TABLE_LIMIT_RESET;
         id_limit_ff    <= ID_LIMIT_RESET;
         valid_ff       <= '0;
         rv_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_TABLE_LIMIT) begin
               table_limit_ff <= csr_wdata;
            end else begin
               id_limit_ff <= csr_wdata[4:0];
            end
         end
         rv_ff <= issue_entry || issue_pair;
         if (state_ff == ST_WRITE) begin
            valid_ff[e_ff] <= 1'b1;
         end
         rsp_valid_ff <= ((state_ff == ST_PAIR) && pair_done && dup_ff) ||
                         (state_ff == ST_WRITE);
      end
   end

   always_ff @(posedge clock) begin
      idx_d_ff     <= idx_ff[IW-1:0];
      rsp_dup_ff   <= (state_ff == ST_PAIR);
      rsp_evict_ff <= (state_ff == ST_WRITE) && evict_ff;
      if (issue_entry) begin
         idx_ff <= idx_ff + CW'(1);
      end
      if ((state_ff == ST_IDLE) && start) begin
         ini_ff        <= req_initiator_addr;
         tgt_ff        <= req_target_addr;
         id_ff         <= req_request_id;
         idx_ff        <= '0;
         hit_ff        <= 1'b0;
         used_ff       <= '0;
         lru_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         dup_ff        <= 1'b0;
      end
      if ((state_ff == ST_SCAN) && rv_ff) begin
         if (valid_ff[idx_d_ff]) begin
            used_ff <= used_ff + CW'(1);
            if (!lru_found_ff || (r_rec > lru_rec_ff)) begin
               lru_found_ff <= 1'b1;
               lru_idx_ff   <= idx_d_ff;
               lru_rec_ff   <= r_rec;
            end
            if (!hit_ff && (r_ini == ini_ff)) begin
               hit_ff      <= 1'b1;
               hit_idx_ff  <= idx_d_ff;
               hit_rec_ff  <= r_rec;
               hit_cnt_ff  <= r_cnt;
               hit_head_ff <= r_head;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx_d_ff;
         end
      end
      if ((state_ff == ST_SCAN) && scan_done) begin
         idx_ff <= '0;
         k_ff   <= '0;
         if (hit_ff) begin
            e_ff        <= hit_idx_ff;
            old_rank_ff <= hit_rec_ff;
            all_ff      <= 1'b0;
            cnt_ff      <= hit_cnt_ff;
            head_ff     <= hit_head_ff;
            slot_ff     <= hit_head_ff;
            evict_ff    <= 1'b0;
         end else begin
            e_ff        <= alloc_evict ? lru_idx_ff : free_idx_ff;
            old_rank_ff <= '0;
            all_ff      <= 1'b1;
            cnt_ff      <= '0;
            head_ff     <= '0;
            slot_ff     <= '0;
            evict_ff    <= alloc_evict;
         end
      end
      if (issue_pair) begin
         k_ff <= k_ff + KW'(1);
         if (slot_next == (SW+1)'(IDS_PER_ENTRY)) begin
            slot_ff <= '0;
         end else begin
            slot_ff <= SW'(slot_next);
         end
      end
      if ((state_ff == ST_PAIR) && rv_ff && (pair_rdata_ff == {tgt_ff, id_ff})) begin
         dup_ff <= 1'b1;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_duplicate  = rsp_dup_ff;
   assign rsp_entry_evicted = rsp_evict_ff;

   `ASSERT_NEXT(a_write_responds, clock, reset, state_ff == ST_WRITE, rsp_valid && !busy)
   `ASSERT_IMPLIES(a_dup_no_evict, clock, reset, rsp_valid, !(rsp_is_duplicate && rsp_entry_evicted))
   `ASSERT_IMPLIES(a_pair_needs_hit, clock, reset, state_ff == ST_PAIR, hit_ff)
   `ASSERT_NEXT(a_accept_scans, clock, reset, start && !busy, state_ff == ST_SCAN)

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// Route request duplicate filter testbench
// Drives route request words with random gaps, predicts the duplicate and
// eviction flags with a table model, and checks every response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import rrdf_pkg::*;

typedef struct packed {
   logic dup;
   logic evict;
} flag_pair_type;

class request_scoreboard;
   localparam int DEPTH = 64;
   localparam int IDS   = 16;
   bit [6:0]   tlimit;
   bit [4:0]   ilimit;
   bit         valid_q[DEPTH];
   bit [31:0]  owner_q[DEPTH];
   int         rank_q[DEPTH];
   int         cnt_q[DEPTH];
   int         head_q[DEPTH];
   bit [31:0]  tgt_q[DEPTH][IDS];
   bit [15:0]  ident_q[DEPTH][IDS];
   flag_pair_type pending[$];
   int         errors;

   function new();
      tlimit = TABLE_LIMIT_RESET;
      ilimit = ID_LIMIT_RESET;
      errors = 0;
      foreach (valid_q[i]) begin
         valid_q[i] = 0;
         cnt_q[i] = 0;
         head_q[i] = 0;
         rank_q[i] = 0;
      end
   endfunction

   function void set_limit(logic idx, bit [6:0] v);
      if (idx == CSR_TABLE_LIMIT) tlimit = v;
      else ilimit = v[4:0];
   endfunction

   function void promote(int e, int old_rank);
      for (int i = 0; i < DEPTH; i++)
         if (i != e && valid_q[i] && rank_q[i] < old_rank) rank_q[i]++;
      rank_q[e] = 0;
   endfunction

   function void note_request(bit [31:0] ini, bit [31:0] tgt, bit [15:0] id);
      int tl, il, e, used, free_e, lru, s;
      flag_pair_type r;
      tl = (tlimit == 0) ? 1 : (tlimit > DEPTH ? DEPTH : tlimit);
      il = (ilimit == 0) ? 1 : (ilimit > IDS ? IDS : ilimit);
      r = '0;
      e = -1;
      for (int i = 0; i < DEPTH; i++)
         if (e < 0 && valid_q[i] && owner_q[i] == ini) e = i;
      if (e >= 0)
         for (int k = 0; k < cnt_q[e]; k++) begin
            s = (head_q[e] + k) % IDS;
            if (tgt_q[e][s] == tgt && ident_q[e][s] == id) r.dup = 1;
         end
      if (!r.dup) begin
         if (e >= 0) promote(e, rank_q[e]);
         else begin
            used = 0; free_e = -1; lru = -1;
            for (int i = 0; i < DEPTH; i++)
               if (valid_q[i]) begin
                  used++;
                  if (lru < 0 || rank_q[i] > rank_q[lru]) lru = i;
               end else if (free_e < 0) free_e = i;
            if ((used >= tl || free_e < 0) && lru >= 0) begin
               valid_q[lru] = 0;
               r.evict = 1;
               e = lru;
            end else e = free_e;
            if (e < 0) e = 0;
            valid_q[e] = 1;
            owner_q[e] = ini;
            cnt_q[e] = 0;
            head_q[e] = 0;
            promote(e, DEPTH);
         end
         if (cnt_q[e] >= il) begin
            head_q[e] = (head_q[e] + 1) % IDS;
            cnt_q[e]--;
         end
         s = (head_q[e] + cnt_q[e]) % IDS;
         tgt_q[e][s] = tgt;
         ident_q[e][s] = id;
         cnt_q[e]++;
      end
      pending.insert(pending.size(), r);
   endfunction

   function void check_response(logic dup, logic evict);
      flag_pair_type x;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected response dup=%0b evict=%0b", dup, evict);
         return;
      end
      x = pending.pop_front();
      if (dup !== x.dup || evict !== x.evict) begin
         errors++;
         if (errors <= 10)
            $display("response: expected dup=%0b evict=%0b, got dup=%0b evict=%0b",
                     x.dup, x.evict, dup, evict);
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [31:0] req_initiator_addr = '0;
   logic [31:0] req_target_addr = '0;
   logic [15:0] req_request_id = '0;
   logic        rsp_valid;
   logic        rsp_is_duplicate;
   logic        rsp_entry_evicted;
   logic        csr_write_en = 0;
   logic        csr_index = 0;
   logic [6:0]  csr_wdata = '0;
   int          cycles = 0;
   request_scoreboard board = new();
   bit [31:0]   ini_pool[8];
   bit [31:0]   tgt_pool[4];

   route_request_duplicate_filter dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("route_request_duplicate_filter: mismatch");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid) board.check_response(rsp_is_duplicate, rsp_entry_evicted);

   task automatic send_word(bit [31:0] ini, bit [31:0] tgt, bit [15:0] id);
      repeat ($urandom_range(0, 19)) @(posedge clock);
      start <= 1;
      req_initiator_addr <= ini;
      req_target_addr <= tgt;
      req_request_id <= id;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(ini, tgt, id);
      start <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, bit [6:0] v);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.set_limit(idx, v);
      csr_write_en <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int n);
      bit [31:0] ini, tgt;
      for (int k = 0; k < n; k++) begin
         ini = ($urandom_range(0, 9) == 0) ? $urandom() : ini_pool[$urandom_range(0, 7)];
         tgt = ($urandom_range(0, 9) == 0) ? $urandom() : tgt_pool[$urandom_range(0, 3)];
         send_word(ini, tgt, ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
                   16'($urandom_range(0, 5)));
      end
   endtask

   initial begin
      bit [6:0] tl_set[6];
      bit [6:0] il_set[6];
      tl_set = '{7'd64, 7'd0, 7'd1, 7'd127, 7'd3, 7'd5};
      il_set = '{7'd16, 7'd31, 7'd0, 7'd1, 7'd2, 7'd4};
      foreach (ini_pool[i]) ini_pool[i] = $urandom();
      foreach (tgt_pool[i]) tgt_pool[i] = $urandom();
      ini_pool[0] = 32'hFFFFFFFF;
      ini_pool[1] = 32'h0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_word(32'h0, 32'h0, 16'h0);
      send_word(32'h0, 32'h0, 16'h0);
      send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
      send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
      send_word(32'h0, 32'hFFFFFFFF, 16'h0);
      send_word(32'h0, 32'h0, 16'hFFFF);
      for (int i = 0; i < 70; i++) send_word(32'h100 + i, 32'h1, 16'h1);
      send_word(32'h0, 32'h0, 16'h0);
      for (int p = 0; p < 6; p++) begin
         drain();
         write_csr(CSR_TABLE_LIMIT, tl_set[p]);
         write_csr(CSR_ID_LIMIT, il_set[p]);
         random_phase(100);
         for (int i = 0; i < 20; i++) send_word(ini_pool[0], 32'h5, 16'(i));
      end
      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("route_request_duplicate_filter: match");
      else
         $display("route_request_duplicate_filter: mismatch");
      $finish;
   end
endmodule

### files.f
+incdir+hdl
hdl/rrdf_pkg.sv
hdl/route_request_duplicate_filter.sv
test/tb.sv
